// ===== rtl/bss_pkg.sv =====
// Package for the BibTeX structure scanner: widths, character codes,
// event codes and the record type passed from the front end to the back end.
// No dependencies.
`default_nettype none

package bss_pkg;

    // Width of the character offset counters and of the signed nesting depth.
    localparam int POS_BITS   = 32;
    localparam int DEPTH_BITS = 16;

    // Record queue between front end and back end.
    localparam int QDEPTH     = 4;
    localparam int QPTR_BITS  = $clog2(QDEPTH);
    localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

    typedef logic [POS_BITS-1:0]          t_pos;
    typedef logic signed [DEPTH_BITS-1:0] t_depth;
    typedef logic [15:0]                  t_char;
    typedef logic [31:0]                  t_word;

    localparam t_depth DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam t_depth DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

    // Characters that steer the scanner.
    localparam t_char CH_PERCENT   = 16'h0025;
    localparam t_char CH_QUOTE     = 16'h0022;
    localparam t_char CH_AT        = 16'h0040;
    localparam t_char CH_LPAREN    = 16'h0028;
    localparam t_char CH_LBRACE    = 16'h007B;
    localparam t_char CH_COMMA     = 16'h002C;
    localparam t_char CH_RPAREN    = 16'h0029;
    localparam t_char CH_RBRACE    = 16'h007D;
    localparam t_char CH_NEWLINE   = 16'h000A;
    localparam t_char CH_BACKSLASH = 16'h005C;

    typedef enum logic [2:0] {
        EV_TYPE_SEG   = 3'd0,
        EV_FIELD_SEG  = 3'd1,
        EV_ENTRY_DONE = 3'd2,
        EV_QUOTE_ERR  = 3'd3,
        EV_AT_ERR     = 3'd4,
        EV_EOF_ERR    = 3'd5,
        EV_END_OK     = 3'd6
    } t_event;

    typedef struct packed {
        logic at_allowed;   // ignore '@' at depth two or more
        logic warn_at;      // report '@' inside an open entry
    } t_cfg;

    // Up to two events of one character; both share position fields.
    typedef struct packed {
        logic   two;
        t_event code0;
        t_event code1;
        t_word  seg_start;
        t_word  seg_end;
        t_word  line;
        t_word  col;
    } t_rec;

endpackage

`default_nettype wire

// ===== rtl/bibtex_structure_scanner_top.sv =====
// Top level of the BibTeX structure scanner: configuration registers and
// wiring of front end, record queue and back end. Depends on bss_pkg,
// bss_front, bss_queue and bss_back.
//
//  channel     direction  handshake                 payload
//  -------     ---------  ---------                 -------
//  characters  in         push / full               i_char_code, i_end_marker
//  events      out        empty / pop               o_event_code .. o_last_event
//  config      in/out     psel, penable, pwrite     paddr, pwdata, prdata
//
// One character is taken every cycle while full is low; the scanner state
// updates in that same cycle and any events go into a four-entry record queue.
// Results leave one per cycle while pop is high, from an output register;
// an entry's closing character yields two results, held for two transfers.
// Reset (synchronous, active low) empties the queue, clears scanner state and
// sets both configuration bits to one. full rises only when the queue is full.
`default_nettype none

module bibtex_structure_scanner_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // character input
    input  wire logic        push,
    output logic             full,
    input  wire logic [15:0] i_char_code,
    input  wire logic        i_end_marker,

    // event output
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       o_event_code,
    output logic [31:0]      o_segment_start,
    output logic [31:0]      o_segment_end,
    output logic [31:0]      o_line_number,
    output logic [31:0]      o_column_number,
    output logic             o_last_event,

    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Configuration registers: byte address 0 and 4, bit 0 only.
    logic          r_at_allowed;
    logic          r_warn_at;
    logic          cfg_wr;
    bss_pkg::t_cfg cfg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_allowed <= 1'b1;
            r_warn_at    <= 1'b1;
        end else if (cfg_wr) begin
            // word select by address bit two; byte offsets within a word alias
            if (paddr[2]) r_warn_at    <= pwdata[0];
            else          r_at_allowed <= pwdata[0];
        end
    end

    assign prdata         = {31'd0, paddr[2] ? r_warn_at : r_at_allowed};
    assign cfg.at_allowed = r_at_allowed;
    assign cfg.warn_at    = r_warn_at;

    // Front end to queue to back end.
    logic          accept;
    logic          q_wr;
    bss_pkg::t_rec q_in;
    logic          q_full;
    logic          q_empty;
    logic          q_rd;
    bss_pkg::t_rec q_out;

    // Hold off characters while the queue cannot take a record.
    assign full   = q_full;
    assign accept = push && !q_full;

    bss_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_char_code  (i_char_code),
        .i_end_marker (i_end_marker),
        .i_cfg        (cfg),
        .o_wr         (q_wr),
        .o_rec        (q_in)
    );

    bss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_rec   (q_in),
        .i_rd    (q_rd),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_rec   (q_out)
    );

    bss_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_q_rec         (q_out),
        .o_q_rd          (q_rd),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_event_code    (o_event_code),
        .o_segment_start (o_segment_start),
        .o_segment_end   (o_segment_end),
        .o_line_number   (o_line_number),
        .o_column_number (o_column_number),
        .o_last_event    (o_last_event)
    );

endmodule

`default_nettype wire

// ===== rtl/bss_front.sv =====
// Front end of the BibTeX structure scanner: scanner state and event detection.
// Depends on bss_pkg.
`default_nettype none

module bss_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire bss_pkg::t_char i_char_code,
    input  wire logic          i_end_marker,
    input  wire bss_pkg::t_cfg i_cfg,
    output logic               o_wr,
    output bss_pkg::t_rec      o_rec
);

    bss_pkg::t_depth r_depth, n_depth;
    logic            r_comment, n_comment;
    logic            r_quote, n_quote;
    logic            r_entry, n_entry;
    logic            r_key, n_key;
    logic            r_bslash, n_bslash;
    bss_pkg::t_pos   r_seg, n_seg;
    bss_pkg::t_pos   r_off, n_off;
    bss_pkg::t_word  r_line, n_line;
    bss_pkg::t_word  r_col, n_col;

    logic            ev_any;
    logic            ev_two;
    bss_pkg::t_event code0;
    bss_pkg::t_event code1;

    always_comb begin
        n_depth   = r_depth;
        n_comment = r_comment;
        n_quote   = r_quote;
        n_entry   = r_entry;
        n_key     = r_key;
        n_bslash  = r_bslash;
        n_seg     = r_seg;
        n_off     = r_off;
        n_line    = r_line;
        n_col     = r_col;
        ev_any    = 1'b0;
        ev_two    = 1'b0;
        code0     = bss_pkg::EV_TYPE_SEG;
        code1     = bss_pkg::EV_ENTRY_DONE;

        if (i_end_marker) begin
            ev_any    = 1'b1;
            code0     = (r_depth > bss_pkg::t_depth'(0)) ? bss_pkg::EV_EOF_ERR
                                                        : bss_pkg::EV_END_OK;
            n_depth   = '0;
            n_comment = 1'b0;
            n_quote   = 1'b0;
            n_entry   = 1'b0;
            n_key     = 1'b0;
            n_bslash  = 1'b0;
            n_seg     = '0;
            n_off     = '0;
            n_line    = 32'd1;
            n_col     = 32'd1;
        end else begin
            case (i_char_code)
                bss_pkg::CH_PERCENT: begin
                    if (r_depth == bss_pkg::t_depth'(0)) n_comment = 1'b1;
                end
                bss_pkg::CH_QUOTE: begin
                    if (!r_comment && r_entry) begin
                        if (r_depth == bss_pkg::t_depth'(1) && r_quote && r_bslash) begin
                            ev_any = 1'b1;
                            code0  = bss_pkg::EV_QUOTE_ERR;
                        end
                        if (!(r_depth >= bss_pkg::t_depth'(2)) && !r_bslash)
                            n_quote = !r_quote;
                    end
                end
                bss_pkg::CH_AT: begin
                    if (!r_comment && !r_quote &&
                        !(i_cfg.at_allowed && r_depth >= bss_pkg::t_depth'(2))) begin
                        if (r_entry && i_cfg.warn_at) begin
                            ev_any = 1'b1;
                            code0  = bss_pkg::EV_AT_ERR;
                        end
                        n_depth = '0;
                        n_entry = 1'b1;
                        n_seg   = r_off;
                    end
                end
                bss_pkg::CH_LPAREN: begin
                    if (!r_comment && r_entry && r_depth == bss_pkg::t_depth'(0)) begin
                        ev_any  = 1'b1;
                        code0   = bss_pkg::EV_TYPE_SEG;
                        n_seg   = r_off;
                        n_depth = bss_pkg::t_depth'(1);
                    end
                end
                bss_pkg::CH_LBRACE: begin
                    if (!r_comment && r_entry) begin
                        n_key = 1'b1;
                        if (r_depth == bss_pkg::t_depth'(0)) begin
                            ev_any = 1'b1;
                            code0  = bss_pkg::EV_TYPE_SEG;
                            n_seg  = r_off;
                        end
                        if (r_depth != bss_pkg::DEPTH_MAX)
                            n_depth = r_depth + bss_pkg::t_depth'(1);
                    end
                end
                bss_pkg::CH_COMMA: begin
                    n_key = 1'b0;
                    if (!r_comment && !r_quote && r_entry &&
                        r_depth == bss_pkg::t_depth'(1)) begin
                        ev_any = 1'b1;
                        code0  = bss_pkg::EV_FIELD_SEG;
                        n_seg  = r_off;
                    end
                end
                bss_pkg::CH_RPAREN: begin
                    if (!r_comment && !r_quote && r_entry && !r_key &&
                        r_depth == bss_pkg::t_depth'(1)) begin
                        ev_any  = 1'b1;
                        ev_two  = 1'b1;
                        code0   = bss_pkg::EV_FIELD_SEG;
                        code1   = bss_pkg::EV_ENTRY_DONE;
                        n_depth = '0;
                        n_entry = 1'b0;
                    end
                end
                bss_pkg::CH_RBRACE: begin
                    if (!r_comment && r_entry) begin
                        // closing depth one ends the last field and the entry
                        if (r_depth == bss_pkg::t_depth'(1)) begin
                            ev_any  = 1'b1;
                            ev_two  = 1'b1;
                            code0   = bss_pkg::EV_FIELD_SEG;
                            code1   = bss_pkg::EV_ENTRY_DONE;
                            n_entry = 1'b0;
                        end
                        if (r_depth != bss_pkg::DEPTH_MIN)
                            n_depth = r_depth - bss_pkg::t_depth'(1);
                    end
                end
                default: begin
                end
            endcase

            if (i_char_code == bss_pkg::CH_NEWLINE) begin
                n_comment = 1'b0;
                n_col     = 32'd1;
                n_line    = r_line + 32'd1;
            end else begin
                n_col     = r_col + 32'd1;
            end
            n_bslash = (i_char_code == bss_pkg::CH_BACKSLASH);
            n_off    = r_off + bss_pkg::t_pos'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth   <= '0;
            r_comment <= 1'b0;
            r_quote   <= 1'b0;
            r_entry   <= 1'b0;
            r_key     <= 1'b0;
            r_bslash  <= 1'b0;
            r_seg     <= '0;
            r_off     <= '0;
            r_line    <= 32'd1;
            r_col     <= 32'd1;
        end else if (i_accept) begin
            r_depth   <= n_depth;
            r_comment <= n_comment;
            r_quote   <= n_quote;
            r_entry   <= n_entry;
            r_key     <= n_key;
            r_bslash  <= n_bslash;
            r_seg     <= n_seg;
            r_off     <= n_off;
            r_line    <= n_line;
            r_col     <= n_col;
        end
    end

    // All events of one character report the segment start held before it.
    assign o_wr            = i_accept && ev_any;
    assign o_rec.two       = ev_two;
    assign o_rec.code0     = code0;
    assign o_rec.code1     = code1;
    assign o_rec.seg_start = 32'(r_seg);
    assign o_rec.seg_end   = 32'(r_off);
    assign o_rec.line      = r_line;
    assign o_rec.col       = r_col;

endmodule

`default_nettype wire

// ===== rtl/bss_queue.sv =====
// Short record queue between scanner front end and result back end.
// Depends on bss_pkg.
`default_nettype none

module bss_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire bss_pkg::t_rec i_rec,
    input  wire logic          i_rd,
    output logic               o_full,
    output logic               o_empty,
    output bss_pkg::t_rec      o_rec
);

    bss_pkg::t_rec                 r_mem [bss_pkg::QDEPTH];
    logic [bss_pkg::QPTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [bss_pkg::QPTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [bss_pkg::QCNT_BITS-1:0] r_count, n_count;

    logic do_wr;
    logic do_rd;

    assign o_full  = (r_count == bss_pkg::QCNT_BITS'(bss_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rec   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_wr ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_rd ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_wr && !do_rd) n_count = r_count + 1'b1;
        if (do_rd && !do_wr) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) r_mem[r_wr_ptr] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bss_pkg::QCNT_BITS'(bss_pkg::QDEPTH))
        else $error("queue count past depth");

    a_no_wr_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("record written into full queue");

endmodule

`default_nettype wire

// ===== rtl/bss_back.sv =====
// Back end of the BibTeX structure scanner: splits records into result
// transfers and holds the current result in an output register. Depends on bss_pkg.
`default_nettype none

module bss_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_empty,
    input  wire bss_pkg::t_rec i_q_rec,
    output logic               o_q_rd,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic [2:0]         o_event_code,
    output logic [31:0]        o_segment_start,
    output logic [31:0]        o_segment_end,
    output logic [31:0]        o_line_number,
    output logic [31:0]        o_column_number,
    output logic               o_last_event
);

    bss_pkg::t_rec r_rec, n_rec;
    logic          r_valid, n_valid;
    logic          r_second, n_second;

    logic take;
    logic done;
    logic load;

    assign take = i_pop && r_valid;
    assign done = take && (r_second || !r_rec.two);
    assign load = (!r_valid || done) && !i_q_empty;

    always_comb begin
        n_rec    = r_rec;
        n_valid  = r_valid;
        n_second = r_second;
        if (load) begin
            n_rec    = i_q_rec;
            n_valid  = 1'b1;
            n_second = 1'b0;
        end else if (done) begin
            n_valid  = 1'b0;
            n_second = 1'b0;
        end else if (take) begin
            // advance to the second event of the record
            n_second = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    assign o_q_rd          = load;
    assign o_empty         = !r_valid;
    assign o_event_code    = r_second ? r_rec.code1 : r_rec.code0;
    assign o_segment_start = r_rec.seg_start;
    assign o_segment_end   = r_rec.seg_end;
    assign o_line_number   = r_rec.line;
    assign o_column_number = r_rec.col;
    assign o_last_event    = r_second || !r_rec.two;

    a_second_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (r_valid && r_rec.two))
        else $error("second event without a two-event record");

    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_rec.two && !r_second) |=> (r_valid && r_second))
        else $error("second event of a record lost");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for bibtex_structure_scanner_top: streams characters in over push/full,
// predicts every scanner event in a scoreboard class and checks events on empty/pop.
// Depends on bss_pkg and the scanner RTL.

module testbench;

    // Configuration register addresses (one 32-bit word per register).
    localparam logic [2:0] ADDR_AT_ALLOWED = 3'd0;
    localparam logic [2:0] ADDR_WARN_AT    = 3'd4;

    localparam bss_pkg::t_char CH_EQUALS       = 16'h003D;
    localparam bss_pkg::t_char CH_SPACE        = 16'h0020;
    localparam int             HOLD_CYCLES     = 80;
    localparam int             ITEMS_PER_PHASE = 225;
    localparam int             DRAIN_CYCLES    = 6;
    localparam int             DEEP_LEVELS     = 6;
    localparam int             NEG_LEVELS      = 5;
    localparam longint         RUN_LIMIT_NS    = 64'd5_000_000;

    // Predicts scanner events from the accepted character stream and checks
    // delivered events against them in order.
    class event_scoreboard;
        typedef struct {
            bss_pkg::t_event code;
            bss_pkg::t_word  seg_start;
            bss_pkg::t_word  seg_end;
            bss_pkg::t_word  line;
            bss_pkg::t_word  col;
            logic            last;
        } scan_event_t;

        bss_pkg::t_cfg   cfg;
        bss_pkg::t_depth depth;
        bit              in_comment;
        bit              in_quote;
        bit              in_entry;
        bit              key_open;
        bit              after_backslash;
        bss_pkg::t_pos   seg_begin;
        bss_pkg::t_pos   offset;
        bss_pkg::t_word  line;
        bss_pkg::t_word  col;
        scan_event_t     expected_events[$];
        int              mismatches;
        int              results_checked;
        int              chars_noted;
        int              code_count[7];

        function new();
            cfg.at_allowed = 1'b1;
            cfg.warn_at    = 1'b1;
            clear_scan();
        endfunction

        function void clear_scan();
            depth           = '0;
            in_comment      = 1'b0;
            in_quote        = 1'b0;
            in_entry        = 1'b0;
            key_open        = 1'b0;
            after_backslash = 1'b0;
            seg_begin       = '0;
            offset          = '0;
            line            = 32'd1;
            col             = 32'd1;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function void add_event(bss_pkg::t_event code);
            scan_event_t ev;
            ev.code      = code;
            ev.seg_start = seg_begin[31:0];
            ev.seg_end   = offset[31:0];
            ev.line      = line;
            ev.col       = col;
            ev.last      = 1'b0;
            expected_events.push_back(ev);
        endfunction

        function void depth_up();
            if (depth < bss_pkg::DEPTH_MAX) depth = depth + 1;
        endfunction

        function void note_input(bss_pkg::t_char c, logic end_item);
            int first;
            first = expected_events.size();
            chars_noted++;
            if (end_item) begin
                add_event(depth > 0 ? bss_pkg::EV_EOF_ERR : bss_pkg::EV_END_OK);
                expected_events[$].last = 1'b1;
                clear_scan();
                return;
            end
            case (c)
                bss_pkg::CH_PERCENT: begin
                    if (depth == 0) in_comment = 1'b1;
                end
                bss_pkg::CH_QUOTE: begin
                    if (!in_comment && in_entry) begin
                        if (depth == 1 && in_quote && after_backslash)
                            add_event(bss_pkg::EV_QUOTE_ERR);
                        if (!(depth >= 2 || after_backslash)) in_quote = !in_quote;
                    end
                end
                bss_pkg::CH_AT: begin
                    if (!in_comment && !in_quote && !(cfg.at_allowed && depth >= 2)) begin
                        if (in_entry && cfg.warn_at) add_event(bss_pkg::EV_AT_ERR);
                        depth     = '0;
                        in_entry  = 1'b1;
                        seg_begin = offset;
                    end
                end
                bss_pkg::CH_LPAREN: begin
                    if (!in_comment && in_entry && depth == 0) begin
                        add_event(bss_pkg::EV_TYPE_SEG);
                        seg_begin = offset;
                        depth_up();
                    end
                end
                bss_pkg::CH_LBRACE: begin
                    if (!in_comment && in_entry) begin
                        key_open = 1'b1;
                        if (depth == 0) begin
                            add_event(bss_pkg::EV_TYPE_SEG);
                            seg_begin = offset;
                        end
                        depth_up();
                    end
                end
                bss_pkg::CH_COMMA: begin
                    key_open = 1'b0;
                    if (!in_comment && !in_quote && in_entry && depth == 1) begin
                        add_event(bss_pkg::EV_FIELD_SEG);
                        seg_begin = offset;
                    end
                end
                bss_pkg::CH_RPAREN: begin
                    if (!in_comment && !in_quote && in_entry && !key_open && depth == 1) begin
                        add_event(bss_pkg::EV_FIELD_SEG);
                        depth    = '0;
                        in_entry = 1'b0;
                        add_event(bss_pkg::EV_ENTRY_DONE);
                    end
                end
                bss_pkg::CH_RBRACE: begin
                    if (!in_comment && in_entry) begin
                        if (depth == 1) add_event(bss_pkg::EV_FIELD_SEG);
                        if (depth > bss_pkg::DEPTH_MIN) depth = depth - 1;
                        if (depth == 0) begin
                            in_entry = 1'b0;
                            add_event(bss_pkg::EV_ENTRY_DONE);
                        end
                    end
                end
                default: ;
            endcase
            if (expected_events.size() > first) expected_events[$].last = 1'b1;
            if (c == bss_pkg::CH_NEWLINE) begin
                in_comment = 1'b0;
                col        = '0;
                line       = line + 1;
            end
            col             = col + 1;
            after_backslash = (c == bss_pkg::CH_BACKSLASH);
            offset          = offset + 1;
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [2:0] code, bss_pkg::t_word s, bss_pkg::t_word e,
                                   bss_pkg::t_word ln, bss_pkg::t_word cl, logic last);
            scan_event_t ev;
            results_checked++;
            if (expected_events.size() == 0) begin
                $error("event with nothing outstanding: event_code %0d, segment_end %0d", code, e);
                mismatches++;
                return;
            end
            ev = expected_events.pop_front();
            code_count[ev.code]++;
            compare_field("event_code", ev.code, code);
            compare_field("segment_start", ev.seg_start, s);
            compare_field("segment_end", ev.seg_end, e);
            compare_field("line_number", ev.line, ln);
            compare_field("column_number", ev.col, cl);
            compare_field("last_event", ev.last, last);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [15:0] i_char_code;
    logic        i_end_marker;
    logic        empty;
    logic        pop;
    logic [2:0]  o_event_code;
    logic [31:0] o_segment_start;
    logic [31:0] o_segment_end;
    logic [31:0] o_line_number;
    logic [31:0] o_column_number;
    logic        o_last_event;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    event_scoreboard sb;

    // Pacing knobs shared by the character source and the event sink.
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;
    bit          hold_req  = 1'b0;

    // Short directed text: a brace entry closing at depth one, a comment line
    // hiding an '@', a paren entry with an escaped quote inside a quote, a nested
    // '@' warning, code zero and the top code, and a paren close once the key
    // flag has been cleared.
    bss_pkg::t_char directed_text [24] = '{
        bss_pkg::CH_AT, 16'h0061, bss_pkg::CH_LBRACE, 16'h006B, bss_pkg::CH_COMMA,
        bss_pkg::CH_LBRACE, bss_pkg::CH_RBRACE, bss_pkg::CH_RBRACE,
        bss_pkg::CH_NEWLINE, bss_pkg::CH_PERCENT, bss_pkg::CH_AT, bss_pkg::CH_NEWLINE,
        bss_pkg::CH_AT, bss_pkg::CH_LPAREN, bss_pkg::CH_QUOTE, bss_pkg::CH_BACKSLASH,
        bss_pkg::CH_QUOTE, 16'h0000, bss_pkg::CH_QUOTE,
        bss_pkg::CH_AT, 16'hFFFF, bss_pkg::CH_LPAREN, bss_pkg::CH_COMMA, bss_pkg::CH_RPAREN
    };

    bibtex_structure_scanner_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_char_code     (i_char_code),
        .i_end_marker    (i_end_marker),
        .empty           (empty),
        .pop             (pop),
        .o_event_code    (o_event_code),
        .o_segment_start (o_segment_start),
        .o_segment_end   (o_segment_end),
        .o_line_number   (o_line_number),
        .o_column_number (o_column_number),
        .o_last_event    (o_last_event),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Event sink: drive pop at the falling edge. A hold request parks pop low
    // for a long stretch so the record queue fills and full backs up the source.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Sample at the rising edge: an event transfers when pop is high and empty low.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sb.check_result(o_event_code, o_segment_start, o_segment_end,
                            o_line_number, o_column_number, o_last_event);
    end

    // Offer one character (or the end item) and hold it until it transfers.
    // Entered and left at a falling edge; push stays high between back-to-back
    // items so it is never dropped and raised in the same step.
    task automatic send_item(bss_pkg::t_char c, logic end_item);
        while ($urandom_range(99) < gap_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push         <= 1'b1;
        i_char_code  <= c;
        i_end_marker <= end_item;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_input(c, end_item);
        @(negedge i_clk);
    endtask

    function automatic bss_pkg::t_char pick_special();
        bss_pkg::t_char specials [10];
        specials = '{bss_pkg::CH_PERCENT, bss_pkg::CH_QUOTE, bss_pkg::CH_AT,
                     bss_pkg::CH_LPAREN, bss_pkg::CH_LBRACE, bss_pkg::CH_COMMA,
                     bss_pkg::CH_RPAREN, bss_pkg::CH_RBRACE, bss_pkg::CH_NEWLINE,
                     bss_pkg::CH_BACKSLASH};
        return specials[$urandom_range(9)];
    endfunction

    task automatic send_word(int len);
        repeat (len) send_item(bss_pkg::t_char'(16'h0061 + $urandom_range(25)), 1'b0);
    endtask

    // Field value content: plain words plus nested groups, escaped quotes,
    // commas and the odd stray control character.
    task automatic send_body();
        repeat ($urandom_range(8)) begin
            case ($urandom_range(9))
                0: begin
                    send_item(bss_pkg::CH_LBRACE, 1'b0);
                    send_word($urandom_range(3));
                    send_item(bss_pkg::CH_RBRACE, 1'b0);
                end
                1: begin
                    send_item(bss_pkg::CH_BACKSLASH, 1'b0);
                    send_item(bss_pkg::CH_QUOTE, 1'b0);
                end
                2: send_item(bss_pkg::CH_COMMA, 1'b0);
                3: send_item(pick_special(), 1'b0);
                4: send_item(CH_SPACE, 1'b0);
                default: send_word(1);
            endcase
        end
    endtask

    // Well-formed entry with random content: @type{key, name = value, ...}
    // with brace, quote or bare values, and either brace or paren delimiters.
    task automatic send_entry();
        bit paren;
        paren = $urandom_range(1);
        send_item(bss_pkg::CH_AT, 1'b0);
        send_word($urandom_range(1, 4));
        send_item(paren ? bss_pkg::CH_LPAREN : bss_pkg::CH_LBRACE, 1'b0);
        send_word($urandom_range(1, 5));
        repeat ($urandom_range(3)) begin
            send_item(bss_pkg::CH_COMMA, 1'b0);
            if ($urandom_range(3) == 0) send_item(bss_pkg::CH_NEWLINE, 1'b0);
            send_word($urandom_range(1, 4));
            send_item(CH_EQUALS, 1'b0);
            case ($urandom_range(2))
                0: begin
                    send_item(bss_pkg::CH_LBRACE, 1'b0);
                    send_body();
                    send_item(bss_pkg::CH_RBRACE, 1'b0);
                end
                1: begin
                    send_item(bss_pkg::CH_QUOTE, 1'b0);
                    send_body();
                    send_item(bss_pkg::CH_QUOTE, 1'b0);
                end
                default: send_item(bss_pkg::t_char'(16'h0030 + $urandom_range(9)), 1'b0);
            endcase
        end
        if ($urandom_range(3) == 0) send_item(bss_pkg::CH_COMMA, 1'b0);
        send_item(paren ? bss_pkg::CH_RPAREN : bss_pkg::CH_RBRACE, 1'b0);
        send_item(bss_pkg::CH_NEWLINE, 1'b0);
    endtask

    // Random text: mostly entries, with comment lines, blank space, raw noise
    // over the full code range and end items mixed in.
    task automatic send_random_text(int count);
        int stop;
        int pick;
        stop = sb.chars_noted + count;
        while (sb.chars_noted < stop) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                send_entry();
            end else if (pick < 72) begin
                send_item(bss_pkg::CH_PERCENT, 1'b0);
                send_body();
                send_item(bss_pkg::CH_NEWLINE, 1'b0);
            end else if (pick < 80) begin
                send_item($urandom_range(1) ? bss_pkg::CH_NEWLINE : CH_SPACE, 1'b0);
            end else if (pick < 95) begin
                repeat ($urandom_range(1, 8))
                    send_item($urandom_range(1) ? pick_special()
                                                : bss_pkg::t_char'($urandom), 1'b0);
            end else begin
                send_item(bss_pkg::t_char'($urandom), 1'b1);
            end
        end
    endtask

    // Drop push and wait until every predicted event has transferred, then keep
    // idling in case a silent character is still in flight.
    task automatic drain();
        push <= 1'b0;
        while (sb.pending() > 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write one register (setup then access cycle) and read it straight back.
    task automatic apb_write(logic [2:0] addr, bit value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {31'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_AT_ALLOWED) sb.cfg.at_allowed = value;
        else sb.cfg.warn_at = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.compare_field("prdata", {31'd0, value}, prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(bit at_allowed, bit warn_at);
        apb_write(ADDR_AT_ALLOWED, at_allowed);
        apb_write(ADDR_WARN_AT, warn_at);
    endtask

    initial begin : stimulus
        sb           = new();
        i_rst_n      = 1'b0;
        push         = 1'b0;
        i_char_code  = '0;
        i_end_marker = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Phase one, no random idling on either side, both options on.
        configure(1'b1, 1'b1);
        foreach (directed_text[i]) send_item(directed_text[i], 1'b0);
        send_item(bss_pkg::t_char'($urandom), 1'b1);

        // Nest a few levels deep, back off by one, and end inside the entry.
        send_item(bss_pkg::CH_AT, 1'b0);
        repeat (DEEP_LEVELS) send_item(bss_pkg::CH_LBRACE, 1'b0);
        send_item(bss_pkg::CH_RBRACE, 1'b0);
        send_item(bss_pkg::t_char'($urandom), 1'b1);

        // Closing braces at depth zero inside an entry push depth negative
        // with no event; step up once and end.
        send_item(bss_pkg::CH_AT, 1'b0);
        repeat (NEG_LEVELS) send_item(bss_pkg::CH_RBRACE, 1'b0);
        send_item(bss_pkg::CH_LBRACE, 1'b0);
        send_item(bss_pkg::t_char'($urandom), 1'b1);

        // Park the sink for a long stretch while entries keep coming.
        hold_req = 1'b1;
        send_random_text(ITEMS_PER_PHASE);
        drain();

        // Phase two: source idles, both options off.
        configure(1'b0, 1'b0);
        gap_pct   = 45;
        stall_pct = 0;
        send_random_text(ITEMS_PER_PHASE);
        drain();

        // Phase three: sink stalls, '@' honored at any depth with warnings on.
        configure(1'b0, 1'b1);
        gap_pct   = 0;
        stall_pct = 45;
        send_random_text(ITEMS_PER_PHASE);
        drain();

        // Phase four: both sides idle, nested '@' warnings off.
        configure(1'b1, 1'b0);
        gap_pct   = 35;
        stall_pct = 35;
        send_random_text(ITEMS_PER_PHASE);
        drain();

        $display("Scanned %0d characters and checked %0d events: type %0d, field %0d, done %0d,",
                 sb.chars_noted, sb.results_checked, sb.code_count[bss_pkg::EV_TYPE_SEG],
                 sb.code_count[bss_pkg::EV_FIELD_SEG], sb.code_count[bss_pkg::EV_ENTRY_DONE]);
        $display("quote %0d, nested at %0d, open at end %0d, clean end %0d; four pacing modes.",
                 sb.code_count[bss_pkg::EV_QUOTE_ERR], sb.code_count[bss_pkg::EV_AT_ERR],
                 sb.code_count[bss_pkg::EV_EOF_ERR], sb.code_count[bss_pkg::EV_END_OK]);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $error("run limit reached with %0d events outstanding", sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== bibtex_structure_scanner_top.f =====
rtl/bss_pkg.sv
rtl/bss_front.sv
rtl/bss_queue.sv
rtl/bss_back.sv
rtl/bibtex_structure_scanner_top.sv
tb/testbench.sv
